@@ rtl/fqt_pkg.sv @@
// shared types and constants of the queue with traversal
package fqt_pkg;

    localparam int DEFAULT_QUEUE_DEPTH = 16;
    localparam int DATA_W              = 32;

    typedef enum logic [1:0] {
        CMD_INSERT   = 2'd0,
        CMD_DELETE   = 2'd1,
        CMD_TRAVERSE = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_DELETED  = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_FULL     = 3'd3,
        ST_ELEMENT  = 3'd4
    } t_status;

    typedef struct packed {
        logic [1:0]               command;
        logic signed [DATA_W-1:0] data_value;
    } t_in_item;

    typedef struct packed {
        logic [2:0]               status;
        logic signed [DATA_W-1:0] item_value;
        logic                     last;
    } t_out_item;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_WALK
    } t_state;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_EXEC,
        OP_WALK
    } t_dp_op;

    typedef struct packed {
        logic cmd_known;
        logic walk_more;
        logic walk_last;
        logic out_free;
    } t_dp_status;

endpackage

@@ rtl/fqt_ctrl.sv @@
// controller state machine sequencing commands and traversal
module fqt_ctrl
    import fqt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_dp_status i_status,
    output logic       o_in_ready,
    output t_dp_op     o_op
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!i_status.cmd_known) begin
                    n_state = S_IDLE;
                end else if (i_status.out_free) begin
                    n_state = i_status.walk_more ? S_WALK : S_IDLE;
                end
            end
            S_WALK: begin
                if (i_status.out_free && i_status.walk_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_op       = OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_op = OP_CAPTURE;
                end
            end
            S_EXEC: begin
                if (i_status.cmd_known && i_status.out_free) begin
                    o_op = OP_EXEC;
                end
            end
            S_WALK: begin
                if (i_status.out_free) begin
                    o_op = OP_WALK;
                end
            end
            default: begin
                o_op = OP_NONE;
            end
        endcase
    end

endmodule

@@ rtl/fqt_datapath.sv @@
// ring storage, pointers, traversal walker and result register
module fqt_datapath
    import fqt_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_op     i_op,
    input  t_in_item   i_in_item,
    input  logic       i_out_ready,
    output t_dp_status o_status,
    output logic       o_out_valid,
    output t_out_item  o_out_item
);

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] slot);
        logic [IDX_W-1:0] v_res;
        if (slot == IDX_W'(QUEUE_DEPTH - 1)) begin
            v_res = '0;
        end else begin
            v_res = slot + IDX_W'(1);
        end
        return v_res;
    endfunction

    logic [DATA_W-1:0] mem [QUEUE_DEPTH];

    logic [IDX_W-1:0]  r_head;
    logic [IDX_W-1:0]  n_head;
    logic [IDX_W-1:0]  r_tail;
    logic [IDX_W-1:0]  n_tail;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic [IDX_W-1:0]  r_walk_slot;
    logic [IDX_W-1:0]  n_walk_slot;
    logic [CNT_W-1:0]  r_walk_left;
    logic [CNT_W-1:0]  n_walk_left;
    t_cmd              r_cmd;
    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] r_rd_data;
    logic              r_out_valid;
    logic              n_out_valid;
    t_out_item         r_out_item;
    t_out_item         n_out_item;

    logic              w_rd_en;
    logic [IDX_W-1:0]  w_rd_addr;
    logic              w_wr_en;
    logic              w_empty;
    logic              w_full;
    logic              w_out_free;
    logic              w_load;
    logic [SUM_W-1:0]  w_sum;
    logic [SUM_W-1:0]  w_ring_tail;

    assign w_empty    = (r_count == '0);
    assign w_full     = (r_count == CNT_W'(QUEUE_DEPTH));
    assign w_out_free = !r_out_valid || i_out_ready;

    assign o_status.cmd_known = (r_cmd == CMD_INSERT) || (r_cmd == CMD_DELETE)
                                || (r_cmd == CMD_TRAVERSE);
    assign o_status.walk_more = (r_cmd == CMD_TRAVERSE) && (r_count > CNT_W'(1));
    assign o_status.walk_last = (r_walk_left == CNT_W'(1));
    assign o_status.out_free  = w_out_free;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    always_comb begin
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_walk_slot = r_walk_slot;
        n_walk_left = r_walk_left;
        n_out_item  = r_out_item;
        w_load      = 1'b0;
        w_rd_en     = 1'b0;
        w_rd_addr   = r_head;
        w_wr_en     = 1'b0;
        unique case (i_op)
            OP_CAPTURE: begin
                w_rd_en   = 1'b1;
                w_rd_addr = r_head;
            end
            OP_EXEC: begin
                w_load = 1'b1;
                n_out_item.item_value = '0;
                n_out_item.last       = 1'b1;
                unique case (r_cmd)
                    CMD_INSERT: begin
                        if (w_full) begin
                            n_out_item.status = ST_FULL;
                        end else begin
                            w_wr_en = 1'b1;
                            n_tail  = ring_next(r_tail);
                            n_count = r_count + CNT_W'(1);
                            n_out_item.status = ST_INSERTED;
                        end
                    end
                    CMD_DELETE: begin
                        if (w_empty) begin
                            n_out_item.status = ST_EMPTY;
                        end else begin
                            n_head  = ring_next(r_head);
                            n_count = r_count - CNT_W'(1);
                            n_out_item.status     = ST_DELETED;
                            n_out_item.item_value = r_rd_data;
                        end
                    end
                    CMD_TRAVERSE: begin
                        if (w_empty) begin
                            n_out_item.status = ST_EMPTY;
                        end else begin
                            n_out_item.status     = ST_ELEMENT;
                            n_out_item.item_value = r_rd_data;
                            n_out_item.last       = (r_count == CNT_W'(1));
                            n_walk_slot = ring_next(r_head);
                            n_walk_left = r_count - CNT_W'(1);
                            w_rd_en     = 1'b1;
                            w_rd_addr   = ring_next(r_head);
                        end
                    end
                    default: begin
                        w_load = 1'b0;
                    end
                endcase
            end
            OP_WALK: begin
                w_load = 1'b1;
                n_out_item.status     = ST_ELEMENT;
                n_out_item.item_value = r_rd_data;
                n_out_item.last       = (r_walk_left == CNT_W'(1));
                n_walk_slot = ring_next(r_walk_slot);
                n_walk_left = r_walk_left - CNT_W'(1);
                w_rd_en     = 1'b1;
                w_rd_addr   = ring_next(r_walk_slot);
            end
            default: begin
                w_load = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_walk_left <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_walk_left <= n_walk_left;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op == OP_CAPTURE) begin
            r_cmd  <= t_cmd'(i_in_item.command);
            r_data <= i_in_item.data_value;
        end
        r_walk_slot <= n_walk_slot;
        r_out_item  <= n_out_item;
    end

    // ring storage, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem[r_tail] <= r_data;
        end
        if (w_rd_en) begin
            r_rd_data <= mem[w_rd_addr];
        end
    end

    always_comb begin
        w_sum = SUM_W'(r_head) + SUM_W'(r_count);
        if (w_sum >= SUM_W'(QUEUE_DEPTH)) begin
            w_ring_tail = w_sum - SUM_W'(QUEUE_DEPTH);
        end else begin
            w_ring_tail = w_sum;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count beyond queue depth");

    a_tail_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ring_tail == SUM_W'(r_tail))
        else $error("tail does not match head plus count");

    a_walk_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == OP_WALK) |-> (r_walk_left != '0))
        else $error("traversal step with nothing left");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == OP_EXEC && r_cmd == CMD_INSERT && !w_full)
        |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("insert did not grow the queue");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> w_out_free)
        else $error("result loaded over a pending item");

endmodule

@@ rtl/fifo_queue_with_traversal_unit.sv @@
// top level of the bounded queue with insert, delete and traverse commands
// insert, delete: capture, then execute once the output is free; next item taken after that
// traverse of n entries: n results, one per cycle if unstalled; one registered memory read port
// an empty traverse gives an EMPTY result; an unknown command is dropped without a result
// reset clears head, tail, count and control; the entry store is not cleared
// results are held in an output register, so an item is taken while a result still waits
module fifo_queue_with_traversal_unit
    import fqt_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    t_dp_op     w_op;
    t_dp_status w_status;

    fqt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (w_status),
        .o_in_ready (o_in_ready),
        .o_op       (w_op)
    );

    fqt_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (w_op),
        .i_in_item   (i_in_item),
        .i_out_ready (i_out_ready),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule
